// ===== hdl/cc20_pkg.sv =====
// Shared types, constants and configuration codes of the ChaCha20 stream cipher.
package cc20_pkg;

  localparam int BLK_WORDS     = 16;
  localparam int BLK_BYTES     = 64;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int HALF_STEPS    = DOUBLE_ROUNDS * 4;
  localparam int STEP_W        = $clog2(HALF_STEPS);
  localparam int POS_W         = $clog2(BLK_BYTES) + 1;
  localparam int WIDX_W        = $clog2(BLK_WORDS);
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  typedef logic [31:0] word_t;
  typedef word_t [BLK_WORDS-1:0] block_t;

  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CTR_INIT = 3'd6;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_lo;
    word_t            nonce_hi;
    word_t            ctr_init;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } qent_t;

  typedef struct packed {
    logic  start;
    logic  abort;
    word_t ctr;
  } core_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_rsp_t;

endpackage

// ===== hdl/cc20_front.sv =====
// Front end: accepts input transactions into a short queue ahead of the cipher back end.
module cc20_front
  import cc20_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       q_vld,
  output qent_t      q_data,
  input  logic       q_pop
);

  qent_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  logic                pop;

  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_vld    = (cnt_r != '0);
  assign pop      = q_pop && q_vld;
  assign q_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_data_byte, eom: in_end_of_message};
    end
  end

endmodule

// ===== hdl/cc20_core.sv =====
// Block generator: ChaCha20 rounds as half quarter rounds on four lanes, one per cycle.
module cc20_core
  import cc20_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  core_req_t req,
  input  cfg_t      cfg,
  output core_rsp_t rsp,
  output block_t    blk
);

  typedef enum logic [2:0] {
    GEN_IDLE = 3'b001,
    GEN_RUN  = 3'b010,
    GEN_FIN  = 3'b100
  } gen_state_t;

  gen_state_t         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  word_t              ctr_r;
  block_t             w_r;
  block_t             init_w;
  block_t             half_w;

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  always_comb begin
    init_w[0] = SIGMA[0];
    init_w[1] = SIGMA[1];
    init_w[2] = SIGMA[2];
    init_w[3] = SIGMA[3];
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = cfg.key[i][31:0];
      init_w[5 + 2 * i] = cfg.key[i][63:32];
    end
    init_w[12] = ctr_r;
    init_w[13] = cfg.nonce_lo[31:0];
    init_w[14] = cfg.nonce_lo[63:32];
    init_w[15] = cfg.nonce_hi;
  end

  always_comb begin
    logic [WIDX_W-1:0] ia, ib, ic, id;
    word_t             a, b, c, d;
    logic              col;
    half_w = w_r;
    col    = ~step_r[1];
    for (int j = 0; j < 4; j++) begin
      ia = WIDX_W'(j);
      ib = col ? WIDX_W'(4 + j) : WIDX_W'(4 + ((j + 1) % 4));
      ic = col ? WIDX_W'(8 + j) : WIDX_W'(8 + ((j + 2) % 4));
      id = col ? WIDX_W'(12 + j) : WIDX_W'(12 + ((j + 3) % 4));
      a  = w_r[ia];
      b  = w_r[ib];
      c  = w_r[ic];
      d  = w_r[id];
      a  = a + b;
      d  = step_r[0] ? rotl(d ^ a, 8) : rotl(d ^ a, 16);
      c  = c + d;
      b  = step_r[0] ? rotl(b ^ c, 7) : rotl(b ^ c, 12);
      half_w[ia] = a;
      half_w[ib] = b;
      half_w[ic] = c;
      half_w[id] = d;
    end
  end

  always_comb begin
    for (int i = 0; i < BLK_WORDS; i++) begin
      blk[i] = w_r[i] + init_w[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      GEN_IDLE: begin
        if (req.start) begin
          state_nxt = GEN_RUN;
          step_nxt  = '0;
        end
      end
      GEN_RUN: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(HALF_STEPS - 1)) begin
          state_nxt = GEN_FIN;
        end
      end
      GEN_FIN: begin
        state_nxt = GEN_IDLE;
      end
      default: begin
        state_nxt = GEN_IDLE;
      end
    endcase
    if (req.abort) begin
      state_nxt = GEN_IDLE;
    end
  end

  assign rsp.idle = (state_r == GEN_IDLE);
  assign rsp.done = (state_r == GEN_FIN) && !req.abort;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GEN_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == GEN_IDLE && req.start) begin
      ctr_r <= req.ctr;
      for (int i = 0; i < BLK_WORDS; i++) begin
        w_r[i] <= (i == 12) ? req.ctr : init_w[i];
      end
    end else if (state_r == GEN_RUN) begin
      w_r <= half_w;
    end
  end

endmodule

// ===== hdl/cc20_back.sv =====
// Back end: holds keystream blocks, combines queued bytes with keystream and drives results.
module cc20_back
  import cc20_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_vld,
  input  qent_t      q_data,
  output logic       q_pop,
  input  logic       cfg_we,
  input  word_t      ctr_init,
  output core_req_t  core_req,
  input  core_rsp_t  core_rsp,
  input  block_t     blk,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_result_byte,
  output logic       out_last_byte
);

  block_t             buf0_r;
  block_t             buf1_r;
  logic               sel_r, sel_nxt;
  logic               spare_vld_r, spare_vld_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               fresh_r, fresh_nxt;
  word_t              ctr_r, ctr_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic               need_new;
  logic               have_ks;
  logic               abort;
  word_t              cur_word;
  logic [7:0]         ks_byte;

  assign need_new = fresh_r || pos_r[POS_W-1];
  assign have_ks  = need_new ? spare_vld_r : 1'b1;
  assign q_pop    = q_vld && have_ks && (!out_vld_r || out_ready);
  assign abort    = cfg_we || (q_pop && q_data.eom);

  assign cur_word = sel_r ? buf1_r[pos_r[POS_W-2:2]] : buf0_r[pos_r[POS_W-2:2]];

  always_comb begin
    if (need_new) begin
      ks_byte = sel_r ? buf0_r[0][7:0] : buf1_r[0][7:0];
    end else begin
      ks_byte = 8'(cur_word >> {pos_r[1:0], 3'b000});
    end
  end

  assign core_req.start = core_rsp.idle && !spare_vld_r && !abort;
  assign core_req.abort = abort;
  assign core_req.ctr   = fresh_r ? ctr_init : ctr_r;

  always_comb begin
    sel_nxt       = sel_r;
    spare_vld_nxt = spare_vld_r;
    pos_nxt       = pos_r;
    fresh_nxt     = fresh_r;
    ctr_nxt       = ctr_r;
    out_vld_nxt   = out_vld_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (core_rsp.done) begin
      spare_vld_nxt = 1'b1;
    end
    if (q_pop) begin
      out_vld_nxt = 1'b1;
      if (need_new) begin
        sel_nxt       = ~sel_r;
        spare_vld_nxt = 1'b0;
        pos_nxt       = POS_W'(1);
        ctr_nxt       = (fresh_r ? ctr_init : ctr_r) + 32'd1;
        fresh_nxt     = 1'b0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (q_data.eom) begin
        fresh_nxt = 1'b1;
        pos_nxt   = POS_W'(BLK_BYTES);
      end
    end
    if (abort) begin
      spare_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      spare_vld_r <= 1'b0;
      pos_r       <= POS_W'(BLK_BYTES);
      fresh_r     <= 1'b1;
      ctr_r       <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      spare_vld_r <= spare_vld_nxt;
      pos_r       <= pos_nxt;
      fresh_r     <= fresh_nxt;
      ctr_r       <= ctr_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_rsp.done && !sel_r) begin
      buf1_r <= blk;
    end
    if (core_rsp.done && sel_r) begin
      buf0_r <= blk;
    end
    if (q_pop) begin
      out_byte_r <= q_data.data ^ ks_byte;
      out_last_r <= q_data.eom;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_byte = out_byte_r;
  assign out_last_byte   = out_last_r;

endmodule

// ===== hdl/chacha20_stream_cipher_top.sv =====
// Top level of the ChaCha20 stream cipher: configuration registers and block wiring.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/ready     in_data_byte, in_end_of_message
//   out_     output     out_valid/ready    out_result_byte, out_last_byte
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// Within a message one byte is taken and delivered per cycle unless output or keystream
// stalls; bytes pass through the input queue and the output register. Blocks are made one
// half quarter round per cycle on four lanes, the next while the current one is consumed.
// The first byte of a message, or the next byte after a configuration write, waits for its
// block. Reset needs no clearing pass; generation starts right after it. A stalled output
// holds its result while the input queue keeps taking transactions until it is full.
module chacha20_stream_cipher_top
  import cc20_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_message,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_result_byte,
  output logic                  out_last_byte,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg_r, cfg_nxt;
  logic      q_vld;
  qent_t     q_data;
  logic      q_pop;
  core_req_t core_req;
  core_rsp_t core_rsp;
  block_t    blk;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY0:     cfg_nxt.key[0]   = cfg_wdata;
        CFG_KEY1:     cfg_nxt.key[1]   = cfg_wdata;
        CFG_KEY2:     cfg_nxt.key[2]   = cfg_wdata;
        CFG_KEY3:     cfg_nxt.key[3]   = cfg_wdata;
        CFG_NONCE_LO: cfg_nxt.nonce_lo = cfg_wdata;
        CFG_NONCE_HI: cfg_nxt.nonce_hi = cfg_wdata[31:0];
        CFG_CTR_INIT: cfg_nxt.ctr_init = cfg_wdata[31:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cc20_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .q_vld             (q_vld),
    .q_data            (q_data),
    .q_pop             (q_pop)
  );

  cc20_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (core_req),
    .cfg   (cfg_r),
    .rsp   (core_rsp),
    .blk   (blk)
  );

  cc20_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_vld           (q_vld),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .cfg_we          (cfg_we),
    .ctr_init        (cfg_r.ctr_init),
    .core_req        (core_req),
    .core_rsp        (core_rsp),
    .blk             (blk),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_byte (out_result_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule

// ===== tb/tb_chacha20_stream_cipher_top.sv =====
// Self-checking testbench of the ChaCha20 byte stream cipher with its own keystream predictor.
module tb_chacha20_stream_cipher_top;
  import cc20_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 48;
  localparam int HOLD_LEN     = 400;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 118;

  localparam bit [7:0] SEL_ALL  = 8'hFF;
  localparam bit [7:0] SEL_KEY  = 8'h0F;
  localparam bit [7:0] SEL_TAIL = 8'hE0;

  localparam logic [3:0][31:0] EXPAND_K = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  class cipher_scoreboard;
    logic [63:0] regs [7];
    logic [31:0] blk_ctr;
    logic [7:0]  ks_buf [64];
    logic [31:0] wk [16];
    int unsigned pos;
    bit          fresh;
    cipher_out_t pending [$];
    int errors, checked, bytes, messages, blocks, wraps;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (ks_buf[i]) ks_buf[i] = '0;
      blk_ctr = '0;
      pos     = BLK_BYTES;
      fresh   = 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
      case (idx)
        CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3, CFG_NONCE_LO: regs[idx] = v;
        CFG_NONCE_HI, CFG_CTR_INIT: regs[idx] = {32'h0, v[31:0]};
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void qround(int a, int b, int c, int d);
      wk[a] += wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 16);
      wk[c] += wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 12);
      wk[a] += wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 8);
      wk[c] += wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 7);
    endfunction

    function void next_keystream_block();
      logic [31:0] init_w [16];
      logic [31:0] v;
      for (int i = 0; i < 4; i++) begin
        init_w[i]         = EXPAND_K[i];
        init_w[4 + 2 * i] = regs[CFG_KEY0 + i][31:0];
        init_w[5 + 2 * i] = regs[CFG_KEY0 + i][63:32];
      end
      init_w[12] = blk_ctr;
      init_w[13] = regs[CFG_NONCE_LO][31:0];
      init_w[14] = regs[CFG_NONCE_LO][63:32];
      init_w[15] = regs[CFG_NONCE_HI][31:0];
      wk = init_w;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
        qround(0, 4, 8, 12);
        qround(1, 5, 9, 13);
        qround(2, 6, 10, 14);
        qround(3, 7, 11, 15);
        qround(0, 5, 10, 15);
        qround(1, 6, 11, 12);
        qround(2, 7, 8, 13);
        qround(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        v = wk[i] + init_w[i];
        for (int j = 0; j < 4; j++) ks_buf[4 * i + j] = v[8 * j +: 8];
      end
    endfunction

    function void note_input(logic [7:0] d, logic eom);
      logic [7:0] ks;
      if (fresh) begin
        blk_ctr = regs[CFG_CTR_INIT][31:0];
        pos     = BLK_BYTES;
        fresh   = 1'b0;
      end
      if (pos >= BLK_BYTES) begin
        next_keystream_block();
        blk_ctr = blk_ctr + 32'd1;
        if (blk_ctr == '0) wraps++;
        pos = 0;
        blocks++;
      end
      ks = ks_buf[pos];
      pos++;
      pending.push_back('{data: d ^ ks, last: eom});
      bytes++;
      if (eom) begin
        fresh = 1'b1;
        messages++;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] d, logic last);
      cipher_out_t exp_out;
      if (pending.size() == 0) begin
        report($sformatf("result %02h last %0b with no transaction pending", d, last));
        return;
      end
      exp_out = pending.pop_front();
      checked++;
      if (d !== exp_out.data)
        report($sformatf("result byte %02h, expected %02h (result %0d)", d, exp_out.data,
                         checked));
      if (last !== exp_out.last)
        report($sformatf("last flag %0b, expected %0b (result %0d)", last, exp_out.last,
                         checked));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n             = 1'b0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte      = '0;
  logic                  in_end_of_message = 1'b0;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic [7:0]            out_result_byte;
  logic                  out_last_byte;
  logic                  cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata         = '0;

  cipher_scoreboard sb;
  logic [63:0] cfg_vals [8];
  int cycles        = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  chacha20_stream_cipher_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_byte   (out_result_byte),
    .out_last_byte     (out_last_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles,
               sb.pending.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(out_result_byte, out_last_byte);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic eom);
    in_valid          <= 1'b1;
    in_data_byte      <= d;
    in_end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    sb.note_input(d, eom);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input bit [7:0] sel);
    for (int i = 0; i < 8; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_wdata <= cfg_vals[i];
        @(posedge clk);
        sb.write_reg(CFG_IDX_W'(i), cfg_vals[i]);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n_items, input int long_pct);
    int sent = 0;
    int len;
    while (sent < n_items) begin
      if ($urandom_range(99) < long_pct) len = $urandom_range(65, 200);
      else len = $urandom_range(1, 20);
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_byte(8'($urandom_range(255)), k == len - 1);
        sent++;
      end
    end
    settle();
  endtask

  initial begin
    bit [7:0] sel;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: all-zero key, nonce and counter.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < 8; i++) cfg_vals[i] = {$urandom, $urandom};
      sel = SEL_ALL;
      case (p)
        0: foreach (cfg_vals[i]) cfg_vals[i] = '1;
        1: cfg_vals[CFG_CTR_INIT] = 64'hFFFF_FFFF_FFFF_FFFE;
        2: sel = SEL_KEY;
        3: begin
          for (int i = 0; i < 4; i++) cfg_vals[CFG_KEY0 + i] = '0;
          cfg_vals[CFG_CTR_INIT] = '0;
        end
        5: sel = SEL_TAIL;
        default: ;
      endcase
      write_regs(sel);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      if (p == 4) hold_requests++;
      run_phase(PHASE_ITEMS, (p == 0) ? 70 : (p == 1) ? 50 : 15);
    end

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    $display("Sent %0d bytes in %0d complete messages over %0d keystream blocks,",
             sb.bytes, sb.messages, sb.blocks);
    $display("%0d counter wraps; checked %0d results across %0d configurations, %0d mismatches.",
             sb.wraps, sb.checked, PHASES + 1, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
